// File: rtl/qds_pkg.sv
`timescale 1ns / 1ps
package qds_pkg;

  // Field widths
  localparam int POS_BITS  = 32;
  localparam int EDGE_BITS = 16;
  localparam int PPR_W     = 16;
  localparam int WPS_W     = 14;
  localparam int RPM_W     = 20;
  localparam int CFG_W     = 16;

  // Speed arithmetic widths: edges * wps, times 60, over ppr * 4
  localparam int PROD_W = EDGE_BITS + WPS_W;
  localparam int NUM_W  = PROD_W + 6;
  localparam int DEN_W  = PPR_W + 2;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Reset values of the configuration registers
  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(96);
  localparam logic [WPS_W-1:0] WPS_RESET = WPS_W'(100);

  // Register indexes
  localparam logic REG_PPR = 1'b0;
  localparam logic REG_WPS = 1'b1;

  // Input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Pin codes that follow each code when turning forward
  localparam logic [1:0] FWD_NEXT [4] = '{2'h2, 2'h0, 2'h3, 2'h1};

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_FWD,
    OP_REV,
    OP_JUMP,
    OP_TICK
  } qds_op_e;

  typedef struct packed {
    logic       command;
    logic [1:0] pin_state;
  } qds_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [19:0]        speed_rpm;
    logic [15:0]        edge_count;
    logic               step_error;
  } qds_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qds_q_st_t;

endpackage

// File: rtl/qds_front.sv
`timescale 1ns / 1ps
module qds_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qds_pkg::qds_in_t  in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output qds_pkg::qds_op_e  push_op_o
);
  import qds_pkg::*;

  logic [1:0] last_pins_q, last_pins_d;
  logic [1:0] diff;

  // Accept whenever the queue has room
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Classify the transaction against the previous sample
  assign diff = in_data_i.pin_state ^ last_pins_q;

  always_comb begin
    priority if (in_data_i.command == CMD_TICK) begin
      push_op_o = OP_TICK;
    end else if (diff == 2'b11) begin
      push_op_o = OP_JUMP;
    end else if (diff == 2'b00) begin
      push_op_o = OP_HOLD;
    end else if (FWD_NEXT[last_pins_q] == in_data_i.pin_state) begin
      push_op_o = OP_FWD;
    end else begin
      push_op_o = OP_REV;
    end
  end

  // Track pin levels on accepted samples
  always_comb begin
    last_pins_d = last_pins_q;
    if (push_o && in_data_i.command == CMD_SAMPLE) begin
      last_pins_d = in_data_i.pin_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
    end else begin
      last_pins_q <= last_pins_d;
    end
  end

endmodule

// File: rtl/qds_queue.sv
`timescale 1ns / 1ps
module qds_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qds_pkg::qds_op_e    op_i,
  input  logic                pop_i,
  output qds_pkg::qds_op_e    op_o,
  output qds_pkg::qds_q_st_t  status_o
);
  import qds_pkg::*;

  qds_op_e         slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   count_q, count_d;

  assign status_o.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign op_o           = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: rtl/qds_back.sv
`timescale 1ns / 1ps
module qds_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [qds_pkg::PPR_W-1:0]   ppr_i,
  input  logic [qds_pkg::WPS_W-1:0]   wps_i,
  input  logic                        empty_i,
  input  qds_pkg::qds_op_e            op_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output qds_pkg::qds_out_t           out_data_o
);
  import qds_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [EDGE_BITS-1:0] edges_q, edges_d;
  logic [RPM_W-1:0]     speed_q, speed_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic                 den_zero_q, den_zero_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  qds_out_t             out_q, out_d;
  logic                 out_free;
  logic [DEN_W:0]       trial;
  logic                 trial_ge;
  logic [NUM_W-1:0]     num;
  logic [RPM_W-1:0]     rpm;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == S_IDLE) && !empty_i && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Numerator: product times sixty as two shifts
  assign num = (NUM_W'(prod_q) << 6) - (NUM_W'(prod_q) << 2);

  // One restoring division step
  assign trial    = {rem_q, quo_q[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, den_q});

  // Saturate the quotient
  assign rpm = (den_zero_q || (|quo_q[NUM_W-1:RPM_W])) ? '1 : quo_q[RPM_W-1:0];

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    edges_d     = edges_q;
    speed_d     = speed_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    den_d       = den_q;
    den_zero_d  = den_zero_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          // Carry out one classified transaction
          out_d.step_error = 1'b0;
          unique case (op_i)
            OP_FWD: begin
              pos_d = pos_q + 1'b1;
              if (edges_q != '1) begin
                edges_d = edges_q + 1'b1;
              end
            end
            OP_REV: begin
              pos_d = pos_q - 1'b1;
              if (edges_q != '1) begin
                edges_d = edges_q + 1'b1;
              end
            end
            OP_JUMP: begin
              out_d.step_error = 1'b1;
            end
            OP_TICK: begin
              prod_d  = PROD_W'(edges_q) * PROD_W'(wps_i);
              edges_d = '0;
              state_d = S_LOAD;
            end
            default: begin
            end
          endcase
          if (op_i != OP_TICK) begin
            out_valid_d      = 1'b1;
            out_d.position   = 32'(signed'(pos_d));
            out_d.speed_rpm  = speed_q;
            out_d.edge_count = 16'(edges_d);
          end
        end
      end
      S_LOAD: begin
        // Load divider operands
        quo_d      = num;
        rem_d      = '0;
        den_d      = {ppr_i, 2'b00};
        den_zero_d = (ppr_i == '0);
        cnt_d      = CNT_W'(NUM_W);
        state_d    = S_DIV;
      end
      S_DIV: begin
        // Shift in one quotient bit per cycle
        rem_d = trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], trial_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output slot frees up
        if (out_free) begin
          speed_d          = rpm;
          out_valid_d      = 1'b1;
          out_d.position   = 32'(signed'(pos_q));
          out_d.speed_rpm  = rpm;
          out_d.edge_count = 16'(edges_q);
          out_d.step_error = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      edges_q     <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      edges_q     <= edges_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    den_zero_q <= den_zero_d;
    out_q      <= out_d;
  end

endmodule

// File: rtl/quadrature_decoder_speed.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  in_data_i   (command, pin_state)
// out      output     out_valid_o/out_ready_i out_data_o (position, speed, edges, error)
// cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// The back end handles a pin sample in its idle state; a window tick runs the multiply,
// operand load and result states around a restoring divider that
// produces one quotient bit per cycle over the 36-bit numerator.
// Reset clears position, edge count, speed and last pin levels and loads
// 96 pulses per revolution and 100 windows per second.
// A stalled output holds the back end; the two-entry queue then stalls the front when full.
module quadrature_decoder_speed (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  qds_pkg::qds_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output qds_pkg::qds_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [qds_pkg::CFG_W-1:0]  cfg_data_i
);
  import qds_pkg::*;

  logic [PPR_W-1:0] ppr_q;
  logic [WPS_W-1:0] wps_q;
  logic             push;
  qds_op_e          push_op;
  logic             pop;
  qds_op_e          pop_op;
  qds_q_st_t        q_st;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= PPR_RESET;
      wps_q <= WPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PPR: ppr_q <= cfg_data_i[PPR_W-1:0];
        REG_WPS: wps_q <= cfg_data_i[WPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (q_st.full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  qds_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (push_op),
    .pop_i    (pop),
    .op_o     (pop_op),
    .status_o (q_st)
  );

  qds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ppr_i       (ppr_q),
    .wps_i       (wps_q),
    .empty_i     (q_st.empty),
    .op_i        (pop_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Never accept into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_st.full |-> !in_ready_o)
    else $error("input accepted while queue full");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_st.empty)
    else $error("pop from empty queue");

  // Queue is never full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_st.full && q_st.empty))
    else $error("queue status inconsistent");

endmodule
